FILE: hdl/vsw_pkg.sv
package vsw_pkg;

  localparam int unsigned ShapeWidth  = 6;
  localparam int unsigned SampleWidth = 10;
  localparam int unsigned ValueWidth  = 16;

  localparam int unsigned PeriodSamples = 1024;
  localparam int unsigned ShapeCount    = 33;
  localparam int unsigned ShapeDiv      = ShapeCount - 2;
  localparam int unsigned RiseStep      = PeriodSamples / 2 - 1;

  localparam int unsigned FracBits    = 20;
  localparam int unsigned DivSteps    = FracBits + 1;
  localparam int unsigned CordicSteps = 18;
  localparam int unsigned NumWidth    = 16;
  localparam int unsigned PhaseWidth  = FracBits + 2;
  localparam int unsigned CordWidth   = 26;

  localparam logic signed [CordWidth-1:0] CordicX0 = 26'sd5093851;

  typedef struct packed {
    logic                 hi;
    logic [NumWidth-1:0]  den2;
    logic [NumWidth-1:0]  rem;
    logic [FracBits:0]    quo;
  } vsw_div_t;

  typedef struct packed {
    logic signed [CordWidth-1:0] x;
    logic signed [CordWidth-1:0] y;
    logic signed [CordWidth-1:0] z;
    logic [PhaseWidth-1:0]       p;
  } vsw_cord_t;

  function automatic logic signed [CordWidth-1:0] vsw_atan(input int unsigned idx);
    logic signed [CordWidth-1:0] a;
    case (idx)
      0:       a = 26'sd8388608;
      1:       a = 26'sd4952084;
      2:       a = 26'sd2616545;
      3:       a = 26'sd1328199;
      4:       a = 26'sd666677;
      5:       a = 26'sd333664;
      6:       a = 26'sd166872;
      7:       a = 26'sd83441;
      8:       a = 26'sd41721;
      9:       a = 26'sd20861;
      10:      a = 26'sd10430;
      11:      a = 26'sd5215;
      12:      a = 26'sd2608;
      13:      a = 26'sd1304;
      14:      a = 26'sd652;
      15:      a = 26'sd326;
      16:      a = 26'sd163;
      17:      a = 26'sd81;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

FILE: hdl/vsw_if.sv
interface vsw_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [vsw_pkg::ShapeWidth-1:0]       shape_index;
  logic [vsw_pkg::SampleWidth-1:0]      sample_index;

  modport source (output valid, shape_index, sample_index, input ready);
  modport sink (input valid, shape_index, sample_index, output ready);
endinterface

interface vsw_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [vsw_pkg::ValueWidth-1:0] sine_value;
  logic signed [vsw_pkg::ValueWidth-1:0] triangle_value;
  logic signed [vsw_pkg::ValueWidth-1:0] saw_value;

  modport source (output valid, sine_value, triangle_value, saw_value, input ready);
  modport sink (input valid, sine_value, triangle_value, saw_value, output ready);
endinterface

FILE: hdl/vsw_div_cell.sv
module vsw_div_cell #(
  parameter int unsigned BitIdx = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  vsw_pkg::vsw_div_t  data_i,
  output logic               valid_o,
  output vsw_pkg::vsw_div_t  data_o
);
  import vsw_pkg::*;

  localparam bit          HasBit = (BitIdx + 1 < NumWidth);
  localparam int unsigned DenBit = HasBit ? BitIdx + 1 : 0;

  logic [NumWidth:0]   r2;
  logic                dbit;
  logic                take;
  vsw_div_t            data_d, data_q;
  logic                valid_q;

  always_comb begin
    dbit = HasBit ? data_i.den2[DenBit] : 1'b0;
    r2   = {data_i.rem, dbit};
    take = (r2 >= {1'b0, data_i.den2});
    data_d      = data_i;
    data_d.rem  = take ? NumWidth'(r2 - {1'b0, data_i.den2}) : NumWidth'(r2);
    data_d.quo  = {data_i.quo[FracBits-1:0], take};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
endmodule

FILE: hdl/vsw_cordic_cell.sv
module vsw_cordic_cell #(
  parameter int unsigned Step = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  vsw_pkg::vsw_cord_t  data_i,
  output logic                valid_o,
  output vsw_pkg::vsw_cord_t  data_o
);
  import vsw_pkg::*;

  logic signed [CordWidth-1:0] dx, dy, ang;
  vsw_cord_t                   data_d, data_q;
  logic                        valid_q;

  always_comb begin
    dx     = data_i.y >>> Step;
    dy     = data_i.x >>> Step;
    ang    = vsw_atan(Step);
    data_d = data_i;
    if (!data_i.z[CordWidth-1]) begin
      data_d.x = data_i.x - dx;
      data_d.y = data_i.y + dy;
      data_d.z = data_i.z - ang;
    end else begin
      data_d.x = data_i.x + dx;
      data_d.y = data_i.y - dy;
      data_d.z = data_i.z + ang;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
endmodule

FILE: hdl/variable_symmetry_waveform_gen.sv
// path: request passes 21 divider cells, then 18 cordic cells, then the output register to the result
// throughput: one request per cycle while the output is not stalled, set by the cell chain advancing together
// the whole chain holds while a finished result waits at the output
// reset: asynchronous active low, clears all valid flags; the data registers are not reset
module variable_symmetry_waveform_gen (
  input logic        clk_i,
  input logic        rst_ni,
  vsw_in_if.sink     req_i,
  vsw_out_if.source  res_o
);
  import vsw_pkg::*;

  logic                     en;
  logic                     out_valid_q;
  logic [ShapeWidth-1:0]    t;
  logic [SampleWidth-1:0]   s;
  logic [14:0]              r, f, sd;
  vsw_div_t                 div_in;

  logic                     dv [DivSteps+1];
  vsw_div_t                 dd [DivSteps+1];
  logic                     cv [CordicSteps+1];
  vsw_cord_t                cd [CordicSteps+1];

  logic [PhaseWidth-1:0]    p_div, p_end;
  logic [FracBits:0]        qq_div, qq_end;
  logic signed [CordWidth-1:0] y_r;
  logic [35:0]              tri_prod;
  logic signed [PhaseWidth:0]  saw_m;
  logic signed [38:0]       saw_prod;
  logic signed [ValueWidth-1:0] sine_d, tri_d, saw_d;
  logic signed [ValueWidth-1:0] sine_q, tri_q, saw_q;

  assign en          = !out_valid_q || res_o.ready;
  assign req_i.ready = en;

  always_comb begin
    t = req_i.shape_index;
    s = req_i.sample_index;
    if (t >= ShapeWidth'(ShapeCount - 1)) begin
      t = ShapeWidth'(ShapeCount - 2);
      s = SampleWidth'(PeriodSamples - 1) - s;
    end
    r  = 15'(ShapeDiv) + 15'(t) * 15'(RiseStep);
    f  = 15'(ShapeDiv * PeriodSamples) - r;
    sd = 15'(s) * 15'(ShapeDiv);
    div_in.hi   = (sd >= r);
    div_in.rem  = div_in.hi ? NumWidth'(sd - r) : NumWidth'(sd);
    div_in.den2 = div_in.hi ? {f, 1'b0} : {r, 1'b0};
    div_in.quo  = '0;
  end

  assign dv[0] = req_i.valid;
  assign dd[0] = div_in;

  for (genvar i = 0; i < DivSteps; i++) begin : g_div
    vsw_div_cell #(.BitIdx(DivSteps - 1 - i)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (dv[i]),
      .data_i  (dd[i]),
      .valid_o (dv[i+1]),
      .data_o  (dd[i+1])
    );
  end

  always_comb begin
    p_div = dd[DivSteps].hi ? PhaseWidth'(dd[DivSteps].quo) + PhaseWidth'(1 << FracBits)
                            : PhaseWidth'(dd[DivSteps].quo);
    if (p_div <= PhaseWidth'(1 << FracBits)) begin
      qq_div = p_div[FracBits:0];
    end else begin
      qq_div = (FracBits+1)'(PhaseWidth'(2 << FracBits) - p_div);
    end
  end

  assign cv[0]   = dv[DivSteps];
  assign cd[0].x = CordicX0;
  assign cd[0].y = '0;
  assign cd[0].z = $signed(CordWidth'({qq_div, 4'b0000}));
  assign cd[0].p = p_div;

  for (genvar j = 0; j < CordicSteps; j++) begin : g_cordic
    vsw_cordic_cell #(.Step(j)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (cv[j]),
      .data_i  (cd[j]),
      .valid_o (cv[j+1]),
      .data_o  (cd[j+1])
    );
  end

  always_comb begin
    p_end = cd[CordicSteps].p;
    if (p_end <= PhaseWidth'(1 << FracBits)) begin
      qq_end = p_end[FracBits:0];
    end else begin
      qq_end = (FracBits+1)'(PhaseWidth'(2 << FracBits) - p_end);
    end
    y_r = (cd[CordicSteps].y + 26'sd128) >>> 8;
    if (y_r < 0) begin
      sine_d = '0;
    end else if (y_r > 26'sd32767) begin
      sine_d = 16'sd32767;
    end else begin
      sine_d = y_r[ValueWidth-1:0];
    end
    tri_prod = 36'(qq_end) * 36'd32767 + 36'd524288;
    tri_d    = tri_prod[35:20];
    saw_m    = $signed({1'b0, p_end}) - $signed((PhaseWidth+1)'(1 << FracBits));
    saw_prod = 39'(saw_m) * 39'sd32767 + 39'sd524288;
    saw_d    = saw_prod[35:20];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= cv[CordicSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sine_q <= sine_d;
      tri_q  <= tri_d;
      saw_q  <= saw_d;
    end
  end

  assign res_o.valid          = out_valid_q;
  assign res_o.sine_value     = sine_q;
  assign res_o.triangle_value = tri_q;
  assign res_o.saw_value      = saw_q;
endmodule

FILE: hdl/vsw_checker.sv
module vsw_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_ready_i,
  input logic                                 out_valid_i,
  input logic                                 out_ready_i,
  input logic signed [vsw_pkg::ValueWidth-1:0] sine_i,
  input logic signed [vsw_pkg::ValueWidth-1:0] tri_i,
  input logic signed [vsw_pkg::ValueWidth-1:0] saw_i
);
  import vsw_pkg::*;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(sine_i) && $stable(saw_i))
    else $error("stalled result changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_i == (!out_valid_i || out_ready_i))
    else $error("request ready does not follow output stall");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !sine_i[ValueWidth-1] && !tri_i[ValueWidth-1])
    else $error("sine or triangle negative");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && saw_i <= 0 |-> (17'(tri_i) - 17'(saw_i)) == 17'sd32767)
    else $error("triangle and saw disagree on rise");
endmodule

bind variable_symmetry_waveform_gen vsw_checker u_vsw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (req_i.ready),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .sine_i      (res_o.sine_value),
  .tri_i       (res_o.triangle_value),
  .saw_i       (res_o.saw_value)
);
